/* src/dtsr_pkg.sv */
// ----------------------------------------------------------------------------
// dtsr_pkg
// Shared constants and types for the deduplicating tile store with
// per-entry reference counts.
// ----------------------------------------------------------------------------
package dtsr_pkg;

    localparam int MAP_COLUMNS   = 128;
    localparam int MAP_ROWS      = 64;
    localparam int TABLE_ENTRIES = 256;

    localparam int CELL_TOTAL = MAP_COLUMNS * MAP_ROWS;
    localparam int CELL_AW    = $clog2(CELL_TOTAL);
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int FILL_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
    localparam int MAP_W      = IDX_W + 1;
    localparam int PAT_W      = 128;

    typedef enum logic [1:0] {
        CMD_COMMIT = 2'd0,
        CMD_PLACE  = 2'd1,
        CMD_SOLID  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_SCAN,
        ST_MISS,
        ST_MOVE,
        ST_INC,
        ST_DEC,
        ST_DONE
    } t_state;

endpackage

/* src/dtsr_ram.sv */
// ----------------------------------------------------------------------------
// dtsr_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dtsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dedup_tile_store_refcount_unit.sv */
// ----------------------------------------------------------------------------
// dedup_tile_store_refcount_unit
// Tile map with a deduplicated, reference-counted table of tile patterns.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell map once, one cell a cycle, so it
// takes no request until the sweep is done. One request is worked on at a
// time. A commit reads the pattern table one entry a cycle through its single
// read port, up to entries_used entries; a place moves the cell's reference
// without a scan, and a set-solid or an out-of-map request touches no table.
// The result sits in an output register, so the next request is taken while
// a result still waits. The map, the pattern table and the counts each live
// in a RAM with registered read data, and the counts are read, changed and
// written back one entry per cycle.
module dedup_tile_store_refcount_unit
    import dtsr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // cell_x[6:0], cell_y[12:7], pattern_low[76:13], pattern_high[140:77],
    // place_index[148:141], solid_value[149], zero[151:150]
    input  logic [151:0] i_s_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status[1:0], cell_index[9:2], appended[10], overwritten[11],
    // entries_used[20:12], zero[23:21]
    output logic [23:0]  o_m_tdata
);

    t_state             r_state, n_state;
    logic [CELL_AW-1:0] r_clr_addr, n_clr_addr;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_out_valid, n_out_valid;
    logic [23:0]        r_out_data, n_out_data;

    t_cmd               r_cmd, n_cmd;
    logic [CELL_AW-1:0] r_cell, n_cell;
    logic [PAT_W-1:0]   r_pat, n_pat;
    logic [IDX_W-1:0]   r_place, n_place;
    logic               r_solid_in, n_solid_in;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic               r_solid_old, n_solid_old;
    logic [IDX_W-1:0]   r_scan, n_scan;
    logic [IDX_W-1:0]   r_target, n_target;
    logic               r_fresh, n_fresh;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_app, n_app;
    logic               r_ovr, n_ovr;

    logic               map_we;
    logic [CELL_AW-1:0] map_waddr, map_raddr;
    logic [MAP_W-1:0]   map_wdata, map_rdata;
    logic               pat_we;
    logic [IDX_W-1:0]   pat_waddr, pat_raddr;
    logic [PAT_W-1:0]   pat_wdata, pat_rdata;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;

    logic [6:0]         in_x;
    logic [5:0]         in_y;
    logic               in_on_map;
    logic [CELL_AW-1:0] in_cell;
    logic [FILL_W-1:0]  scan_next;
    logic               s_accept;

    assign in_x      = i_s_tdata[6:0];
    assign in_y      = i_s_tdata[12:7];
    assign in_on_map = (int'(in_x) < MAP_COLUMNS) && (int'(in_y) < MAP_ROWS);
    assign in_cell   = CELL_AW'(int'(in_y) * MAP_COLUMNS + int'(in_x));
    assign scan_next = {1'b0, r_scan} + FILL_W'(1);

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_cmd       = r_cmd;
        n_cell      = r_cell;
        n_pat       = r_pat;
        n_place     = r_place;
        n_solid_in  = r_solid_in;
        n_prev      = r_prev;
        n_solid_old = r_solid_old;
        n_scan      = r_scan;
        n_target    = r_target;
        n_fresh     = r_fresh;
        n_status    = r_status;
        n_idx       = r_idx;
        n_app       = r_app;
        n_ovr       = r_ovr;

        map_we    = 1'b0;
        map_waddr = r_cell;
        map_wdata = {r_solid_old, r_target};
        map_raddr = in_cell;
        pat_we    = 1'b0;
        pat_waddr = r_prev;
        pat_wdata = r_pat;
        pat_raddr = scan_next[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = r_target;
        cnt_wdata = cnt_rdata + CNT_W'(1);
        cnt_raddr = r_prev;

        unique case (r_state)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
                map_wdata = '0;
                // seed entry 0 on the first sweep cycle
                if (r_clr_addr == '0) begin
                    pat_we    = 1'b1;
                    pat_waddr = '0;
                    pat_wdata = '1;
                    cnt_we    = 1'b1;
                    cnt_waddr = '0;
                    cnt_wdata = CNT_W'(CELL_TOTAL);
                end
                n_clr_addr = r_clr_addr + CELL_AW'(1);
                if (r_clr_addr == CELL_AW'(CELL_TOTAL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_cmd      = t_cmd'(i_s_tuser);
                    n_cell     = in_cell;
                    n_pat      = i_s_tdata[140:13];
                    n_place    = IDX_W'(i_s_tdata[148:141]);
                    n_solid_in = i_s_tdata[149];
                    n_status   = STAT_OK;
                    n_idx      = '0;
                    n_app      = 1'b0;
                    n_ovr      = 1'b0;
                    n_state    = in_on_map ? ST_MAP : ST_DONE;
                end
            end
            ST_MAP: begin
                n_prev      = map_rdata[IDX_W-1:0];
                n_solid_old = map_rdata[MAP_W-1];
                n_idx       = map_rdata[IDX_W-1:0];
                n_fresh     = 1'b0;
                pat_raddr   = '0;
                n_scan      = '0;
                unique case (r_cmd)
                    CMD_COMMIT: begin
                        n_state = ST_SCAN;
                    end
                    CMD_PLACE: begin
                        if ({1'b0, r_place} < r_fill) begin
                            n_target = r_place;
                            n_state  = ST_MOVE;
                        end else begin
                            n_status = STAT_BAD_INDEX;
                            n_state  = ST_DONE;
                        end
                    end
                    CMD_SOLID: begin
                        map_we      = 1'b1;
                        map_wdata   = {r_solid_in, map_rdata[IDX_W-1:0]};
                        n_solid_old = r_solid_in;
                        n_state     = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                // count of the old entry is read here in case of a miss
                priority if (pat_rdata == r_pat) begin
                    n_target = r_scan;
                    n_state  = ST_MOVE;
                end else if (scan_next >= r_fill) begin
                    n_state = ST_MISS;
                end else begin
                    n_scan = scan_next[IDX_W-1:0];
                end
            end
            ST_MISS: begin
                priority if (cnt_rdata == CNT_W'(1)) begin
                    pat_we    = 1'b1;
                    pat_waddr = r_prev;
                    n_ovr     = 1'b1;
                    n_state   = ST_DONE;
                end else if (r_fill < FILL_W'(TABLE_ENTRIES)) begin
                    pat_we    = 1'b1;
                    pat_waddr = r_fill[IDX_W-1:0];
                    n_target  = r_fill[IDX_W-1:0];
                    n_fresh   = 1'b1;
                    n_app     = 1'b1;
                    n_fill    = r_fill + FILL_W'(1);
                    n_state   = ST_MOVE;
                end else begin
                    n_status = STAT_FULL;
                    n_state  = ST_DONE;
                end
            end
            ST_MOVE: begin
                if (r_target == r_prev) begin
                    n_idx   = r_target;
                    n_state = ST_DONE;
                end else begin
                    cnt_raddr = r_target;
                    n_state   = ST_INC;
                end
            end
            ST_INC: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_target;
                cnt_wdata = r_fresh ? CNT_W'(1) : cnt_rdata + CNT_W'(1);
                cnt_raddr = r_prev;
                n_state   = ST_DEC;
            end
            ST_DEC: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_prev;
                cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : '0;
                map_we    = 1'b1;
                map_wdata = {r_solid_old, r_target};
                n_idx     = r_target;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_fill, r_ovr, r_app, 8'(r_idx), r_status};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_fill      <= FILL_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_out_data  <= n_out_data;
        r_cmd       <= n_cmd;
        r_cell      <= n_cell;
        r_pat       <= n_pat;
        r_place     <= n_place;
        r_solid_in  <= n_solid_in;
        r_prev      <= n_prev;
        r_solid_old <= n_solid_old;
        r_scan      <= n_scan;
        r_target    <= n_target;
        r_fresh     <= n_fresh;
        r_status    <= n_status;
        r_idx       <= n_idx;
        r_app       <= n_app;
        r_ovr       <= n_ovr;
    end

    dtsr_ram #(
        .WIDTH (MAP_W),
        .DEPTH (CELL_TOTAL)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    dtsr_ram #(
        .WIDTH (PAT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (pat_wdata),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    dtsr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

endmodule

/* bench/tile_store_checker.sv */
// ----------------------------------------------------------------------------
// tile_store_checker
// Watches both stream channels of the tile store. It keeps its own copy of
// the cell map, the pattern table and the use counts, works out the result
// of every accepted request and compares each returned result, field by
// field, with the oldest one still due.
// ----------------------------------------------------------------------------
module tile_store_checker
    import dtsr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // cell_x[6:0], cell_y[12:7], pattern_low[76:13], pattern_high[140:77],
    // place_index[148:141], solid_value[149], zero[151:150]
    input  logic [151:0] i_s_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // status[1:0], cell_index[9:2], appended[10], overwritten[11],
    // entries_used[20:12], zero[23:21]
    input  logic [23:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_results_due
);

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  cell_index;
        logic              appended;
        logic              overwritten;
        logic [FILL_W-1:0] entries_used;
    } t_tile_result;

    logic [IDX_W-1:0] cell_entry    [CELL_TOTAL];
    logic             cell_solid    [CELL_TOTAL];
    logic [PAT_W-1:0] tile_patterns [TABLE_ENTRIES];
    int unsigned      ref_counts    [TABLE_ENTRIES];
    int unsigned      entries_filled;
    t_tile_result     tile_results_due [$];
    int               fail_count = 0;

    // Move one reference from the cell's current entry to the target entry.
    function automatic void retarget_cell(int cell_addr, int target);
        int prev;
        prev = int'(cell_entry[cell_addr]);
        cell_entry[cell_addr] = IDX_W'(target);
        ref_counts[target] += 1;
        if (ref_counts[prev] > 0)
            ref_counts[prev] -= 1;
    endfunction

    function automatic t_tile_result store_request(t_cmd cmd, logic [6:0] x,
                                                   logic [5:0] y,
                                                   logic [PAT_W-1:0] pat,
                                                   logic [7:0] place,
                                                   logic solid);
        t_tile_result r;
        int cell_addr;
        int prev;
        int hit;
        r.status      = STAT_OK;
        r.cell_index  = '0;
        r.appended    = 1'b0;
        r.overwritten = 1'b0;
        if (int'(x) < MAP_COLUMNS && int'(y) < MAP_ROWS) begin
            cell_addr = int'(y) * MAP_COLUMNS + int'(x);
            prev = int'(cell_entry[cell_addr]);
            case (cmd)
                CMD_COMMIT: begin
                    // lowest equal entry wins
                    hit = -1;
                    for (int i = 0; i < int'(entries_filled) && hit < 0; i++)
                        if (tile_patterns[i] == pat)
                            hit = i;
                    if (hit >= 0) begin
                        retarget_cell(cell_addr, hit);
                    end else if (ref_counts[prev] == 1) begin
                        tile_patterns[prev] = pat;
                        r.overwritten = 1'b1;
                    end else if (entries_filled < TABLE_ENTRIES) begin
                        tile_patterns[entries_filled] = pat;
                        ref_counts[entries_filled] = 0;
                        entries_filled += 1;
                        retarget_cell(cell_addr, int'(entries_filled) - 1);
                        r.appended = 1'b1;
                    end else begin
                        r.status = STAT_FULL;
                    end
                end
                CMD_PLACE: begin
                    if (place < entries_filled)
                        retarget_cell(cell_addr, int'(place));
                    else
                        r.status = STAT_BAD_INDEX;
                end
                CMD_SOLID: begin
                    cell_solid[cell_addr] = solid;
                end
                default: ;
            endcase
            r.cell_index = cell_entry[cell_addr];
        end
        r.entries_used = FILL_W'(entries_filled);
        return r;
    endfunction

    function automatic bit field_ok(string name, int unsigned want, int unsigned got);
        if (want == got)
            return 1'b1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_tile_result want;
        bit ok;
        if (!i_rst_n) begin
            for (int c = 0; c < CELL_TOTAL; c++) begin
                cell_entry[c] = '0;
                cell_solid[c] = 1'b0;
            end
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                tile_patterns[e] = '0;
                ref_counts[e]    = 0;
            end
            tile_patterns[0] = '1;
            ref_counts[0]    = CELL_TOTAL;
            entries_filled   = 1;
            tile_results_due.delete();
        end else begin
            // check the returned result before queuing a new request
            if (i_m_tvalid && i_m_tready) begin
                if (tile_results_due.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want = tile_results_due.pop_front();
                    ok = field_ok("status", want.status, i_m_tdata[1:0])
                       & field_ok("cell_index", want.cell_index, i_m_tdata[9:2])
                       & field_ok("appended", want.appended, i_m_tdata[10])
                       & field_ok("overwritten", want.overwritten, i_m_tdata[11])
                       & field_ok("entries_used", want.entries_used, i_m_tdata[20:12]);
                    if (!ok)
                        fail_count++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                tile_results_due.push_back(store_request(t_cmd'(i_s_tuser),
                                                         i_s_tdata[6:0],
                                                         i_s_tdata[12:7],
                                                         i_s_tdata[140:13],
                                                         i_s_tdata[148:141],
                                                         i_s_tdata[149]));
        end
        o_results_due <= tile_results_due.size();
        o_fail_count  <= fail_count;
    end

endmodule

/* bench/tb_dedup_tile_store_refcount_unit.sv */
// ----------------------------------------------------------------------------
// tb_dedup_tile_store_refcount_unit
// Drives commit, place, set-solid and unused requests into the tile store:
// a directed opening on hits, appends, in-place rewrites, bad indexes and
// zero-count entries, then random requests drawn from a shared pattern pool
// and a set of busy cells so that the table fills up. Both sides idle at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_dedup_tile_store_refcount_unit;
    import dtsr_pkg::*;

    localparam int REQUESTS  = 1000;
    localparam int POOL_SIZE = 300;
    localparam int HOT_CELLS = 16;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    // cell_x[6:0], cell_y[12:7], pattern_low[76:13], pattern_high[140:77],
    // place_index[148:141], solid_value[149], zero[151:150]
    logic [151:0] s_data  = '0;
    // command[1:0]
    logic [1:0]   s_user  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    // status[1:0], cell_index[9:2], appended[10], overwritten[11],
    // entries_used[20:12], zero[23:21]
    logic [23:0]  m_data;
    logic         quiet   = 1'b0;
    int           fail_count;
    int           results_due;

    logic [PAT_W-1:0] tile_pool [POOL_SIZE];
    logic [6:0]       hot_x [HOT_CELLS];
    logic [5:0]       hot_y [HOT_CELLS];

    always #1 i_clk = ~i_clk;

    dedup_tile_store_refcount_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    tile_store_checker tile_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_user),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // Result side: after each taken result, drop tready for a random stall, or not at all while quiet is set.
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            stall_left = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                stall_left = quiet ? 0 : $urandom_range(0, 5);
            else if (stall_left > 0)
                stall_left--;
            m_ready <= (stall_left == 0);
        end
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(input t_cmd cmd, input logic [6:0] x, input logic [5:0] y,
                                input logic [PAT_W-1:0] pat, input logic [7:0] place,
                                input logic solid);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {2'b00, solid, place, pat, y, x};
        do @(posedge i_clk); while (!s_ready);
    endtask

    initial begin
        int           pick;
        int           h;
        t_cmd         cmd;
        logic [6:0]   x;
        logic [5:0]   y;
        logic [PAT_W-1:0] pat;
        logic [7:0]   place;
        logic         solid;

        for (int p = 0; p < POOL_SIZE; p++)
            tile_pool[p] = {$urandom, $urandom, $urandom, $urandom};
        for (int c = 0; c < HOT_CELLS; c++) begin
            hot_x[c] = 7'($urandom);
            hot_y[c] = 6'($urandom);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hit on the cell's own entry, append, then rewrite the sole-use entry
        send_request(CMD_COMMIT, 7'd0, 6'd0, '1, 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd127, 6'd63, '0, 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd127, 6'd63, tile_pool[1], 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd0, 6'd0, tile_pool[1], 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd0, 6'd0, tile_pool[2], 8'd0, 1'b0);
        send_request(CMD_PLACE, 7'd5, 6'd5, '0, 8'd1, 1'b0);
        send_request(CMD_PLACE, 7'd5, 6'd5, '0, 8'd255, 1'b0);
        send_request(CMD_PLACE, 7'd1, 6'd1, '0, 8'd3, 1'b0);
        send_request(CMD_PLACE, 7'd0, 6'd0, '0, 8'd0, 1'b0);
        send_request(CMD_SOLID, 7'd127, 6'd0, '0, 8'd0, 1'b1);
        send_request(CMD_SOLID, 7'd127, 6'd0, '0, 8'd0, 1'b0);
        send_request(CMD_SOLID, 7'd0, 6'd63, '1, 8'd255, 1'b1);
        send_request(CMD_NONE, 7'd5, 6'd5, '1, 8'd255, 1'b1);
        send_request(CMD_COMMIT, 7'd127, 6'd63, '1, 8'd0, 1'b0);
        // drop the last reference to entry 1, then hit it again
        send_request(CMD_PLACE, 7'd5, 6'd5, '0, 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd2, 6'd2, tile_pool[1], 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd3, 6'd3, {64{2'b10}}, 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd3, 6'd3, {64{2'b01}}, 8'd0, 1'b0);
        send_request(CMD_COMMIT, 7'd100, 6'd50, tile_pool[2], 8'd0, 1'b0);

        for (int n = 0; n < REQUESTS; n++) begin
            if (n % 100 == 0)
                quiet <= ($urandom_range(0, 3) == 0);
            if (n == REQUESTS / 2) begin
                // drain the block before going on
                s_valid <= 1'b0;
                do @(posedge i_clk); while (results_due != 0);
            end
            x     = 7'($urandom);
            y     = 6'($urandom);
            pat   = {$urandom, $urandom, $urandom, $urandom};
            place = 8'($urandom);
            solid = 1'($urandom);
            if ($urandom_range(0, 9) < 3) begin
                h = $urandom_range(0, HOT_CELLS - 1);
                x = hot_x[h];
                y = hot_y[h];
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                cmd = CMD_COMMIT;
                h = $urandom_range(0, 19);
                if (h < 17)
                    pat = tile_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (h == 17)
                    pat = '1;
            end else if (pick < 78) begin
                cmd = CMD_PLACE;
                if (pick < 70)
                    place = 8'($urandom_range(0, 63));
            end else if (pick < 93) begin
                cmd = CMD_SOLID;
            end else begin
                cmd = CMD_NONE;
            end
            send_request(cmd, x, y, pat, place, solid);
        end

        s_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
